### design/gatf_pkg.sv
`timescale 1ns / 1ps

package gatf_pkg;

   // Fixed field widths
   localparam int SCORE_W = 32;
   localparam int COL_W   = 6;
   localparam int IDX_W   = 7;
   localparam int SYM_W   = 8;
   localparam int CFG_W   = 8;
   localparam int CSR_A_W = 3;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [CFG_W-1:0]   weight_type;

   // Request commands
   localparam logic [1:0] CMD_LOAD_TOP = 2'd0;
   localparam logic [1:0] CMD_LOAD_SYM = 2'd1;
   localparam logic [1:0] CMD_ROW      = 2'd2;

   // Register indexes
   localparam logic [CSR_A_W-1:0] REG_MATCH    = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_MISMATCH = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_GAP      = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_COLS     = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_ROWS     = 3'd4;

   // Register reset values
   localparam weight_type       MATCH_RESET    = 8'sd5;
   localparam weight_type       MISMATCH_RESET = -8'sd4;
   localparam weight_type       GAP_RESET      = -8'sd5;
   localparam logic [IDX_W-1:0] COLS_RESET     = 7'd64;
   localparam logic [IDX_W-1:0] ROWS_RESET     = 7'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Sequencer to cell unit
   typedef struct packed {
      logic             row_start;
      logic             corner_wr;
      logic             issue;
      logic             last;
      logic [COL_W-1:0] col;
   } ctl_type;

   // Cell unit to sequencer
   typedef struct packed {
      logic hold;
      logic busy;
   } sts_type;

   function automatic logic [SCORE_W-1:0] sext_weight(input weight_type w);
      return {{(SCORE_W-CFG_W){w[CFG_W-1]}}, w};
   endfunction

endpackage

### design/gatf_store.sv
`timescale 1ns / 1ps

module gatf_store import gatf_pkg::*; #(
   parameter int TILE_COLS = 64,
   parameter int AW        = 6
) (
   input  logic             clock,
   input  logic             up_we,
   input  logic [AW-1:0]    up_waddr,
   input  score_type        up_wdata,
   input  logic             sym_we,
   input  logic [AW-1:0]    sym_waddr,
   input  logic [SYM_W-1:0] sym_wdata,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output score_type        rd_up_ff,
   output logic [SYM_W-1:0] rd_sym_ff
);

   // Row above (entry j = score above column j) and column symbols
   score_type        up_mem  [TILE_COLS];
   logic [SYM_W-1:0] sym_mem [TILE_COLS];

   always_ff @(posedge clock) begin
      if (up_we) begin
         up_mem[up_waddr] <= up_wdata;
      end
      if (sym_we) begin
         sym_mem[sym_waddr] <= sym_wdata;
      end
      if (rd_en) begin
         rd_up_ff  <= up_mem[rd_addr];
         rd_sym_ff <= sym_mem[rd_addr];
      end
   end

endmodule

### design/gatf_seq.sv
`timescale 1ns / 1ps

module gatf_seq import gatf_pkg::*; #(
   parameter int TILE_COLS = 64,
   parameter int TILE_ROWS = 64,
   parameter int AW        = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_cmd,
   input  logic [IDX_W-1:0] req_index,
   input  logic [IDX_W-1:0] cols_in_use,
   input  logic [IDX_W-1:0] rows_in_use,
   input  sts_type          sts,
   output logic             req_ready,
   output ctl_type          ctl,
   output logic [AW-1:0]    rd_addr,
   output logic             up_load_we,
   output logic             sym_load_we
);

   state_type        state_ff, state_in;
   logic [AW-1:0]    col_ff, col_in;
   logic [IDX_W-1:0] rows_done_ff, rows_done_in;
   logic [IDX_W-1:0] ncols;
   logic             accept;
   logic             row_ok;

   // Columns in use, clamped to the tile
   assign ncols = (cols_in_use > IDX_W'(TILE_COLS)) ? IDX_W'(TILE_COLS) : cols_in_use;
   assign row_ok = (rows_done_ff < rows_in_use) && (int'(rows_done_ff) < TILE_ROWS);

   // Outputs
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      accept        = req_valid && req_ready;
      ctl.row_start = accept && (req_cmd == CMD_ROW) && row_ok;
      ctl.corner_wr = accept && (req_cmd == CMD_LOAD_TOP) && (req_index == '0);
      up_load_we    = accept && (req_cmd == CMD_LOAD_TOP) && (req_index != '0)
                      && (int'(req_index) <= TILE_COLS);
      sym_load_we   = accept && (req_cmd == CMD_LOAD_SYM) && (int'(req_index) < TILE_COLS);
      ctl.issue     = (state_ff == ST_RUN) && !sts.hold;
      ctl.last      = (IDX_W'(col_ff) == ncols - 7'd1);
      ctl.col       = COL_W'(col_ff);
      rd_addr       = col_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.row_start && (ncols != '0)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (ctl.issue && ctl.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Column counter and row count
   always_comb begin
      col_in       = col_ff;
      rows_done_in = rows_done_ff;
      if (ctl.row_start) begin
         col_in = '0;
      end else if (ctl.issue) begin
         col_in = col_ff + AW'(1);
      end
      if (ctl.corner_wr) begin
         rows_done_in = '0;
      end else if (ctl.row_start) begin
         rows_done_in = rows_done_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         rows_done_ff <= '0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         rows_done_ff <= rows_done_in;
      end
   end

endmodule

### design/gatf_cell.sv
`timescale 1ns / 1ps

module gatf_cell import gatf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ctl_type          ctl,
   input  score_type        rd_up,
   input  logic [SYM_W-1:0] rd_sym,
   input  score_type        req_score_in,
   input  logic [SYM_W-1:0] req_row_symbol,
   input  weight_type       match_score,
   input  weight_type       mismatch_score,
   input  weight_type       gap_score,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [COL_W-1:0] rsp_column,
   output score_type        rsp_score,
   output logic             rsp_last,
   output sts_type          sts,
   output logic             wb_we,
   output logic [COL_W-1:0] wb_col,
   output score_type        wb_score
);

   score_type        corner_ff;
   score_type        diag_ff;
   score_type        left_ff;
   logic [SYM_W-1:0] rsym_ff;

   // Stage 1 control (read data sits in the store)
   logic             v1_ff;
   logic             last1_ff;
   logic [COL_W-1:0] col1_ff;

   // Stage 2
   logic             v2_ff;
   logic             last2_ff;
   logic [COL_W-1:0] col2_ff;
   score_type        m1_ff;

   logic             rsp_valid_ff;
   logic [COL_W-1:0] rsp_column_ff;
   score_type        rsp_score_ff;
   logic             rsp_last_ff;

   logic             hold;
   score_type        gap_ext;
   score_type        up_g;
   score_type        diag_s;
   score_type        m1_in;
   score_type        left_g;
   score_type        best;

   assign hold    = rsp_valid_ff && !rsp_ready;
   assign gap_ext = sext_weight(gap_score);

   // Stage 1: up and diagonal candidates
   always_comb begin
      up_g   = rd_up + gap_ext;
      diag_s = diag_ff + ((rd_sym == rsym_ff) ? sext_weight(match_score)
                                              : sext_weight(mismatch_score));
      m1_in  = (diag_s > up_g) ? diag_s : up_g;
   end

   // Stage 2: left candidate closes the row recurrence
   always_comb begin
      left_g = left_ff + gap_ext;
      best   = (left_g > m1_ff) ? left_g : m1_ff;
   end

   // Control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (!hold) begin
         v1_ff        <= ctl.issue;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   // Datapath flops
   always_ff @(posedge clock) begin
      if (ctl.corner_wr) begin
         corner_ff <= req_score_in;
      end
      if (ctl.row_start) begin
         corner_ff <= req_score_in;
         diag_ff   <= corner_ff;
         left_ff   <= req_score_in;
         rsym_ff   <= req_row_symbol;
      end
      if (!hold) begin
         if (ctl.issue) begin
            last1_ff <= ctl.last;
            col1_ff  <= ctl.col;
         end
         if (v1_ff) begin
            m1_ff    <= m1_in;
            diag_ff  <= rd_up;
            last2_ff <= last1_ff;
            col2_ff  <= col1_ff;
         end
         if (v2_ff) begin
            left_ff       <= best;
            rsp_score_ff  <= best;
            rsp_column_ff <= col2_ff;
            rsp_last_ff   <= last2_ff;
         end
      end
   end

   assign wb_we    = v2_ff && !hold;
   assign wb_col   = col2_ff;
   assign wb_score = best;

   assign sts.hold = hold;
   assign sts.busy = v1_ff || v2_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_column = rsp_column_ff;
   assign rsp_score  = rsp_score_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### design/global_alignment_tile_fill.sv
`timescale 1ns / 1ps
// Tile fill for global alignment with a linear gap penalty.
// Request channel (req_*): cmd 0 loads a top boundary entry (index 0 is the
// corner and starts a new tile), cmd 1 loads a column symbol, cmd 2 computes
// one tile row from its row symbol and left boundary score.
// Response channel (rsp_*): one score per column in use, column 0 first,
// rsp_last on the final column. Loads and rows beyond rows_in_use give none.
// CSR port: csr_we writes csr_wdata into register csr_index at once; write it
// only while the block is idle.
// Flow: a load leaves req_ready high. A row holds req_ready low while one
// cell enters the shared cell unit per cycle, except while a stall holds it;
// then two stages (candidates, then the left recurrence) run dry before the
// next request. Scores are registered at the store read and in each stage.
// Stall: while rsp_valid waits for rsp_ready the whole cell pipeline freezes;
// the last score of a row may wait while the next request is accepted.
// Reset: registers return to their defaults, the row count clears, no
// response is pending. Boundary and symbol stores hold no reset value.
module global_alignment_tile_fill import gatf_pkg::*; #(
   parameter int TILE_COLS = 64,
   parameter int TILE_ROWS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [IDX_W-1:0]   req_index,
   input  score_type          req_score_in,
   input  logic [SYM_W-1:0]   req_col_symbol,
   input  logic [SYM_W-1:0]   req_row_symbol,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COL_W-1:0]   rsp_column,
   output score_type          rsp_score,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_index,
   input  logic [CFG_W-1:0]   csr_wdata
);

   localparam int AW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

   weight_type       match_ff;
   weight_type       mismatch_ff;
   weight_type       gap_ff;
   logic [IDX_W-1:0] cols_ff;
   logic [IDX_W-1:0] rows_ff;

   ctl_type          ctl;
   sts_type          sts;
   logic [AW-1:0]    rd_addr;
   logic             up_load_we;
   logic             sym_load_we;
   logic             wb_we;
   logic [COL_W-1:0] wb_col;
   score_type        wb_score;
   score_type        rd_up;
   logic [SYM_W-1:0] rd_sym;
   logic             up_we;
   logic [AW-1:0]    up_waddr;
   score_type        up_wdata;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= MATCH_RESET;
         mismatch_ff <= MISMATCH_RESET;
         gap_ff      <= GAP_RESET;
         cols_ff     <= COLS_RESET;
         rows_ff     <= ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_MATCH:    match_ff    <= csr_wdata;
            REG_MISMATCH: mismatch_ff <= csr_wdata;
            REG_GAP:      gap_ff      <= csr_wdata;
            REG_COLS:     cols_ff     <= csr_wdata[IDX_W-1:0];
            REG_ROWS:     rows_ff     <= csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // Boundary loads and cell write-back share the row store write port
   assign up_we    = up_load_we || wb_we;
   assign up_waddr = wb_we ? AW'(wb_col) : AW'(req_index - 7'd1);
   assign up_wdata = wb_we ? wb_score : req_score_in;

   gatf_seq #(
      .TILE_COLS (TILE_COLS),
      .TILE_ROWS (TILE_ROWS),
      .AW        (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_cmd     (req_cmd),
      .req_index   (req_index),
      .cols_in_use (cols_ff),
      .rows_in_use (rows_ff),
      .sts         (sts),
      .req_ready   (req_ready),
      .ctl         (ctl),
      .rd_addr     (rd_addr),
      .up_load_we  (up_load_we),
      .sym_load_we (sym_load_we)
   );

   gatf_store #(
      .TILE_COLS (TILE_COLS),
      .AW        (AW)
   ) u_store (
      .clock     (clock),
      .up_we     (up_we),
      .up_waddr  (up_waddr),
      .up_wdata  (up_wdata),
      .sym_we    (sym_load_we),
      .sym_waddr (AW'(req_index)),
      .sym_wdata (req_col_symbol),
      .rd_en     (ctl.issue),
      .rd_addr   (rd_addr),
      .rd_up_ff  (rd_up),
      .rd_sym_ff (rd_sym)
   );

   gatf_cell u_cell (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .rd_up          (rd_up),
      .rd_sym         (rd_sym),
      .req_score_in   (req_score_in),
      .req_row_symbol (req_row_symbol),
      .match_score    (match_ff),
      .mismatch_score (mismatch_ff),
      .gap_score      (gap_ff),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_column     (rsp_column),
      .rsp_score      (rsp_score),
      .rsp_last       (rsp_last),
      .sts            (sts),
      .wb_we          (wb_we),
      .wb_col         (wb_col),
      .wb_score       (wb_score)
   );

endmodule

### design/gatf_checker.sv
`timescale 1ns / 1ps

module gatf_checker import gatf_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [COL_W-1:0] rsp_column,
   input score_type        rsp_score,
   input logic             rsp_last
);

   // Expected column of the next response
   logic [COL_W-1:0] next_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_col_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         next_col_ff <= rsp_last ? '0 : rsp_column + 6'd1;
      end
   end

   // Stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score)
         && $stable(rsp_column) && $stable(rsp_last))
      else $error("response changed while stalled");

   // Reset leaves the block ready with nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // Columns of a row come out in order from zero
   a_col_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_column == next_col_ff)
      else $error("response column out of order");

   // No new request while a row is still producing
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a row");

endmodule

bind global_alignment_tile_fill gatf_checker u_gatf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_column (rsp_column),
   .rsp_score  (rsp_score),
   .rsp_last   (rsp_last)
);
